>>> rtl/bmp_rle8_decoder_defines.svh
// Assertion macros for the RLE8 decoder RTL.
// Needs nothing else; bmp_rle8_decoder takes it by include.
`ifndef BMP_RLE8_DECODER_DEFINES_SVH
`define BMP_RLE8_DECODER_DEFINES_SVH

// ante true at an edge implies cons at the same edge
`define RLE8_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante true at an edge implies cons at the next edge
`define RLE8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rle8_pkg.sv
// Types and constants for the BMP RLE8 decoder.
// No dependencies; imported by bmp_rle8_decoder, rle8_fill_checker and testbench.
`default_nettype none

package rle8_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int PAD_W     = 2;
    localparam int PTR_W     = 25;
    localparam int BYTE_W    = 8;

    localparam logic [PTR_W-1:0] ADDR_MAX = {PTR_W{1'b1}};

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_LINE_PADDING = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_idx_t;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_RUNVAL = 7'b0000010,
        PH_ESC    = 7'b0000100,
        PH_ABS    = 7'b0001000,
        PH_PAD    = 7'b0010000,
        PH_DX     = 7'b0100000,
        PH_DY     = 7'b1000000
    } phase_t;

    // escape codes following a zero byte
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    typedef struct packed {
        logic [PTR_W-1:0]  fill_address;
        logic [BYTE_W-1:0] fill_length;
        logic [BYTE_W-1:0] fill_value;
        logic              done_res;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/bmp_rle8_decoder.sv
// BMP RLE8 decoder: compressed byte stream in, frame-buffer fill words out.
// Uses rle8_pkg and the assertion macros in bmp_rle8_decoder_defines.svh.
//
// Usage:
//   Input channel s_*: one compressed byte per word, with first (start of a
//   new image, clears pointers and parse state) and last (final byte).
//   Output channel m_*: fill words (address, length, value, done). A byte gives
//   zero or one word; escapes, counts and pads give only a done word at image end.
//   Config port: cfg_wr_en / cfg_addr / cfg_wdata write image_width (0),
//   line_padding (1), image_height (2). Stride and buffer end are derived
//   in a register, so s_ready drops in the cycle after each write.
//   Throughput: one byte per cycle while s_ready is high. At the accept edge a byte's fill word
//   goes into the output register, or the skid while that holds a word, and
//   single-pass logic updates parse state (one 8 x stride multiply for delta).
//   Stall: an output register plus a one-word skid register; bytes keep
//   being accepted while one word waits; s_ready falls when both hold.
//   Reset (aresetn low, synchronous): both output slots empty, parse state
//   cleared, width = 1, padding = 0, height = 1.
`default_nettype none

module bmp_rle8_decoder
    import rle8_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_W-1:0]    s_data_byte,
    input  wire logic                 s_first,
    input  wire logic                 s_last,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [PTR_W-1:0]          m_fill_address,
    output logic [BYTE_W-1:0]         m_fill_length,
    output logic [BYTE_W-1:0]         m_fill_value,
    output logic                      m_done_res
);

`include "bmp_rle8_decoder_defines.svh"

    localparam int STRIDE_W = $clog2(MAX_WIDTH + 4);
    localparam int HGT_W    = $clog2(MAX_HEIGHT + 1);
    localparam int PROD_W   = STRIDE_W + HGT_W;
    localparam int EXT_W    = (PROD_W > PTR_W) ? PROD_W : PTR_W;
    localparam int DY_W     = STRIDE_W + BYTE_W;
    localparam int SUM_W    = ((DY_W > PTR_W) ? DY_W : PTR_W) + 2;
    localparam int LS_W     = ((STRIDE_W > PTR_W) ? STRIDE_W : PTR_W) + 1;

    // configuration
    logic [CFG_W-1:0]    image_width_reg;
    logic [PAD_W-1:0]    line_padding_reg;
    logic [CFG_W-1:0]    image_height_reg;
    logic                cfg_settle_reg;
    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [PTR_W-1:0]    end_reg, end_next;

    logic [31:0]         w32, h32;
    logic [EXT_W-1:0]    end_ext;

    // parse state
    phase_t              phase_reg, phase_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [PTR_W-1:0]    ls_reg, ls_next;
    logic [BYTE_W-1:0]   cnt_reg, cnt_next;
    logic [BYTE_W-1:0]   dx_reg, dx_next;
    logic                pad_reg, pad_next;
    logic                fin_reg, fin_next;

    phase_t              e_phase;
    logic [PTR_W-1:0]    e_wp, e_ls;
    logic [BYTE_W-1:0]   e_cnt, e_dx;
    logic                e_pad, e_fin;

    logic [PTR_W-1:0]    room;
    logic [BYTE_W-1:0]   cnt_dec;
    logic [DY_W-1:0]     dy_prod;
    logic [SUM_W-1:0]    dy_sum;
    logic [LS_W-1:0]     ls_inc;
    logic                fill, done;
    logic [PTR_W-1:0]    f_addr;
    logic [BYTE_W-1:0]   f_len, f_val;
    logic                res_valid;
    result_t             res;

    // output register and skid
    logic                out_v_reg, out_v_next;
    logic                skid_v_reg, skid_v_next;
    result_t             out_reg, out_next;
    result_t             skid_reg, skid_next;
    logic                accept, pop;

    assign accept = s_valid && s_ready;
    assign pop    = out_v_reg && m_ready;
    assign s_ready = !skid_v_reg && !cfg_settle_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= CFG_W'(1);
            line_padding_reg <= '0;
            image_height_reg <= CFG_W'(1);
            cfg_settle_reg   <= 1'b1;
        end else begin
            cfg_settle_reg <= cfg_wr_en;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                    CFG_LINE_PADDING: line_padding_reg <= cfg_wdata[PAD_W-1:0];
                    CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        w32 = 32'(image_width_reg);
        if (w32 == 32'd0) begin
            w32 = 32'd1;
        end else if (w32 > 32'(MAX_WIDTH)) begin
            w32 = 32'(MAX_WIDTH);
        end
        h32 = 32'(image_height_reg);
        if (h32 == 32'd0) begin
            h32 = 32'd1;
        end else if (h32 > 32'(MAX_HEIGHT)) begin
            h32 = 32'(MAX_HEIGHT);
        end
        stride_next = STRIDE_W'(w32 + 32'(line_padding_reg));
        end_ext     = EXT_W'(stride_next) * EXT_W'(h32[HGT_W-1:0]);
        if (end_ext > EXT_W'(ADDR_MAX)) begin
            end_next = ADDR_MAX;
        end else begin
            end_next = PTR_W'(end_ext);
        end
    end

    always_ff @(posedge aclk) begin
        stride_reg <= stride_next;
        end_reg    <= end_next;
    end

    // ---------------- parse step ----------------
    always_comb begin
        e_phase = s_first ? PH_IDLE : phase_reg;
        e_wp    = s_first ? '0 : wp_reg;
        e_ls    = s_first ? '0 : ls_reg;
        e_cnt   = s_first ? '0 : cnt_reg;
        e_dx    = s_first ? '0 : dx_reg;
        e_pad   = s_first ? 1'b0 : pad_reg;
        e_fin   = s_first ? 1'b0 : fin_reg;

        phase_next = e_phase;
        wp_next    = e_wp;
        ls_next    = e_ls;
        cnt_next   = e_cnt;
        dx_next    = e_dx;
        pad_next   = e_pad;
        fin_next   = e_fin;

        room    = end_reg - e_wp;
        cnt_dec = e_cnt - 8'd1;
        dy_prod = DY_W'(s_data_byte) * DY_W'(stride_reg);
        dy_sum  = SUM_W'(e_wp) + SUM_W'(e_dx) + SUM_W'(dy_prod);
        ls_inc  = LS_W'(e_ls) + LS_W'(stride_reg);

        fill      = 1'b0;
        done      = 1'b0;
        f_addr    = e_wp;
        f_len     = '0;
        f_val     = '0;
        res_valid = 1'b0;
        res       = '{fill_address: e_wp, fill_length: '0, fill_value: '0, done_res: 1'b1};

        if (e_fin) begin
            res_valid = 1'b0;
        end else if (e_wp >= end_reg) begin
            fin_next  = 1'b1;
            res_valid = 1'b1;
        end else begin
            unique case (e_phase)
                PH_RUNVAL: begin
                    fill   = 1'b1;
                    f_len  = (PTR_W'(e_cnt) < room) ? e_cnt : BYTE_W'(room);
                    f_val  = s_data_byte;
                    wp_next    = e_wp + PTR_W'(f_len);
                    phase_next = PH_IDLE;
                end
                PH_ESC: begin
                    if (s_data_byte == ESC_EOL) begin
                        if (ls_inc > LS_W'(end_reg)) begin
                            ls_next = end_reg;
                        end else begin
                            ls_next = PTR_W'(ls_inc);
                        end
                        wp_next    = ls_next;
                        phase_next = PH_IDLE;
                    end else if (s_data_byte == ESC_EOB) begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end else if (s_data_byte == ESC_DELTA) begin
                        phase_next = PH_DX;
                    end else begin
                        cnt_next   = s_data_byte;
                        pad_next   = s_data_byte[0];
                        phase_next = PH_ABS;
                    end
                end
                PH_ABS: begin
                    fill     = 1'b1;
                    f_len    = 8'd1;
                    f_val    = s_data_byte;
                    wp_next  = e_wp + PTR_W'(1);
                    cnt_next = cnt_dec;
                    if (cnt_dec == '0) begin
                        phase_next = e_pad ? PH_PAD : PH_IDLE;
                    end
                end
                PH_PAD: begin
                    pad_next   = 1'b0;
                    phase_next = PH_IDLE;
                end
                PH_DX: begin
                    dx_next    = s_data_byte;
                    phase_next = PH_DY;
                end
                PH_DY: begin
                    if (dy_sum > SUM_W'(end_reg)) begin
                        wp_next = end_reg;
                    end else begin
                        wp_next = PTR_W'(dy_sum);
                    end
                    phase_next = PH_IDLE;
                end
                default: begin
                    if (s_data_byte == '0) begin
                        phase_next = PH_ESC;
                    end else begin
                        cnt_next   = s_data_byte;
                        phase_next = PH_RUNVAL;
                    end
                end
            endcase

            if (wp_next >= end_reg || s_last) begin
                done = 1'b1;
            end
            if (done) begin
                fin_next = 1'b1;
            end
            if (fill) begin
                res_valid = 1'b1;
                res = '{fill_address: f_addr, fill_length: f_len,
                        fill_value: f_val, done_res: done};
            end else if (done) begin
                res_valid = 1'b1;
                res = '{fill_address: wp_next, fill_length: '0,
                        fill_value: '0, done_res: 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            wp_reg    <= '0;
            ls_reg    <= '0;
            cnt_reg   <= '0;
            dx_reg    <= '0;
            pad_reg   <= 1'b0;
            fin_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            wp_reg    <= wp_next;
            ls_reg    <= ls_next;
            cnt_reg   <= cnt_next;
            dx_reg    <= dx_next;
            pad_reg   <= pad_next;
            fin_reg   <= fin_next;
        end
    end

    // ---------------- output register and skid ----------------
    always_comb begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        out_next    = out_reg;
        skid_next   = skid_reg;
        if (skid_v_reg) begin
            if (pop) begin
                out_next    = skid_reg;
                skid_v_next = 1'b0;
            end
        end else if (accept && res_valid) begin
            if (!out_v_reg || pop) begin
                out_next   = res;
                out_v_next = 1'b1;
            end else begin
                skid_next   = res;
                skid_v_next = 1'b1;
            end
        end else if (pop) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid        = out_v_reg;
    assign m_fill_address = out_reg.fill_address;
    assign m_fill_length  = out_reg.fill_length;
    assign m_fill_value   = out_reg.fill_value;
    assign m_done_res     = out_reg.done_res;

    // ---------------- assertions ----------------
    `RLE8_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_v_reg, out_v_reg, "skid holds a word while output register is empty")
    `RLE8_ASSERT_NOW(a_zero_len_is_done, aclk, aresetn, m_valid && (m_fill_length == '0), m_done_res, "zero-length word without done")
    `RLE8_ASSERT_NEXT(a_finished_holds, aclk, aresetn, fin_reg && !(accept && s_first), $stable(wp_reg) && fin_reg, "finished image changed its pointer")
    `RLE8_ASSERT_NEXT(a_cfg_settle, aclk, aresetn, cfg_wr_en, !s_ready, "byte accepted before stride and end settled")

endmodule

`default_nettype wire

>>> bench/rle8_fill_checker.sv
`timescale 1ns / 100ps
// Fill-word checker for bmp_rle8_decoder: follows register writes and accepted bytes,
// predicts each fill word, and compares the words leaving the block field by field.
// Depends on rle8_pkg for widths, phase codes, escape codes and the result layout.
module rle8_fill_checker
    import rle8_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_data_byte,
    input  logic                 s_first,
    input  logic                 s_last,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [PTR_W-1:0]     m_fill_address,
    input  logic [BYTE_W-1:0]    m_fill_length,
    input  logic [BYTE_W-1:0]    m_fill_value,
    input  logic                 m_done_res,
    output int                   errors,
    output int                   pending
);

    localparam int                MAX_W    = DEF_MAX_WIDTH;
    localparam int                MAX_H    = DEF_MAX_HEIGHT;
    localparam logic [BYTE_W-1:0] ESC_MARK = 8'h00;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [PAD_W-1:0]  pad_reg;
    phase_t            phase;
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  row_start;
    logic [BYTE_W-1:0] count_left;
    logic [BYTE_W-1:0] dx_hold;
    logic              pad_due;
    logic              image_done;
    result_t           fills_due[$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic [31:0] row_bytes();
        logic [31:0] w;
        w = 32'(width_reg);
        if (w < 32'd1) w = 32'd1;
        if (w > 32'(MAX_W)) w = 32'(MAX_W);
        return w + 32'(pad_reg);
    endfunction

    function automatic logic [31:0] buffer_end();
        logic [31:0] h;
        logic [31:0] e;
        h = 32'(height_reg);
        if (h < 32'd1) h = 32'd1;
        if (h > 32'(MAX_H)) h = 32'(MAX_H);
        e = row_bytes() * h;
        if (e > 32'(ADDR_MAX)) e = 32'(ADDR_MAX);
        return e;
    endfunction

    task automatic clear_image();
        phase      = PH_IDLE;
        wr_ptr     = '0;
        row_start  = '0;
        count_left = '0;
        dx_hold    = '0;
        pad_due    = 1'b0;
        image_done = 1'b0;
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        if (errors < 40)
            $display("mismatch in %s: got %0d, want %0d", field, got, want);
        errors++;
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic first_in,
                               input logic last_in);
        logic [31:0] stride;
        logic [31:0] fin;
        logic [31:0] ptr;
        logic [31:0] room;
        logic [31:0] n;
        logic [31:0] rs;
        logic        fill;
        logic        done;
        result_t     r;
        stride = row_bytes();
        fin    = buffer_end();
        fill   = 1'b0;
        done   = 1'b0;
        r      = '0;
        if (first_in) clear_image();
        if (image_done) return;
        if (32'(wr_ptr) >= fin) begin
            image_done     = 1'b1;
            r.fill_address = wr_ptr;
            r.done_res     = 1'b1;
            fills_due.push_back(r);
            return;
        end
        ptr = 32'(wr_ptr);
        case (phase)
            PH_RUNVAL: begin
                room           = fin - ptr;
                n              = (32'(count_left) < room) ? 32'(count_left) : room;
                fill           = 1'b1;
                r.fill_address = ptr[PTR_W-1:0];
                r.fill_length  = n[BYTE_W-1:0];
                r.fill_value   = b;
                ptr            = ptr + n;
                phase          = PH_IDLE;
            end
            PH_ESC: begin
                if (b == ESC_EOL) begin
                    rs = 32'(row_start) + stride;
                    if (rs > fin) rs = fin;
                    row_start = rs[PTR_W-1:0];
                    ptr       = rs;
                    phase     = PH_IDLE;
                end else if (b == ESC_EOB) begin
                    done  = 1'b1;
                    phase = PH_IDLE;
                end else if (b == ESC_DELTA) begin
                    phase = PH_DX;
                end else begin
                    count_left = b;
                    pad_due    = b[0];
                    phase      = PH_ABS;
                end
            end
            PH_ABS: begin
                fill           = 1'b1;
                r.fill_address = ptr[PTR_W-1:0];
                r.fill_length  = 8'd1;
                r.fill_value   = b;
                ptr            = ptr + 32'd1;
                count_left     = count_left - 8'd1;
                if (count_left == '0) phase = pad_due ? PH_PAD : PH_IDLE;
            end
            PH_PAD: begin
                pad_due = 1'b0;
                phase   = PH_IDLE;
            end
            PH_DX: begin
                dx_hold = b;
                phase   = PH_DY;
            end
            PH_DY: begin
                ptr = ptr + 32'(dx_hold) + 32'(b) * stride;
                if (ptr > fin) ptr = fin;
                phase = PH_IDLE;
            end
            default: begin
                if (b == ESC_MARK) begin
                    phase = PH_ESC;
                end else begin
                    count_left = b;
                    phase      = PH_RUNVAL;
                end
            end
        endcase
        wr_ptr = ptr[PTR_W-1:0];
        if (ptr >= fin) done = 1'b1;
        if (last_in) done = 1'b1;
        if (done) image_done = 1'b1;
        if (fill) begin
            r.done_res = done;
            fills_due.push_back(r);
        end else if (done) begin
            r.fill_address = ptr[PTR_W-1:0];
            r.done_res     = 1'b1;
            fills_due.push_back(r);
        end
    endtask

    task automatic check_word();
        result_t want;
        if (fills_due.size() == 0) begin
            report("word with nothing due, fill_address", 32'(m_fill_address), '0);
            return;
        end
        want = fills_due.pop_front();
        if (m_fill_address !== want.fill_address)
            report("fill_address", 32'(m_fill_address), 32'(want.fill_address));
        if (m_fill_length !== want.fill_length)
            report("fill_length", 32'(m_fill_length), 32'(want.fill_length));
        if (m_fill_value !== want.fill_value)
            report("fill_value", 32'(m_fill_value), 32'(want.fill_value));
        if (m_done_res !== want.done_res)
            report("done_res", 32'(m_done_res), 32'(want.done_res));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = 13'd1;
            pad_reg    = '0;
            height_reg = 13'd1;
            clear_image();
            fills_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_IMAGE_WIDTH:  width_reg  = cfg_wdata;
                    CFG_LINE_PADDING: pad_reg    = cfg_wdata[PAD_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) check_word();
            if (s_valid && s_ready) decode_byte(s_data_byte, s_first, s_last);
        end
        pending = fills_due.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Top of the bmp_rle8_decoder bench: clock, reset, register writes and RLE8 byte streams.
// Depends on rle8_pkg, the decoder RTL and rle8_fill_checker, which gives the failure count.
module testbench;
    import rle8_pkg::*;

    localparam int                   ITEMS         = 1750;
    localparam int                   SETTLE_CYCLES = 4;
    localparam int                   LIMIT         = 2000;
    localparam logic [BYTE_W-1:0]    ESC_MARK      = 8'h00;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_data_byte;
    logic                 s_first;
    logic                 s_last;
    logic                 m_valid;
    logic                 m_ready;
    logic [PTR_W-1:0]     m_fill_address;
    logic [BYTE_W-1:0]    m_fill_length;
    logic [BYTE_W-1:0]    m_fill_value;
    logic                 m_done_res;

    int                   errors;
    int                   pending;
    int                   sent;
    int                   quiet_cycles;
    bit                   calm;
    logic [BYTE_W-1:0]    stream[$];

    bmp_rle8_decoder u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_first        (s_first),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fill_address (m_fill_address),
        .m_fill_length  (m_fill_length),
        .m_fill_value   (m_fill_value),
        .m_done_res     (m_done_res)
    );

    rle8_fill_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_first        (s_first),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fill_address (m_fill_address),
        .m_fill_length  (m_fill_length),
        .m_fill_value   (m_fill_value),
        .m_done_res     (m_done_res),
        .errors         (errors),
        .pending        (pending)
    );

    always #2 aclk = ~aclk;

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic f, input logic l);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_first     <= f;
        s_last      <= l;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // hold the sender until every due word has left the block
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] p,
                            input logic [CFG_W-1:0] h, input bit poke_spare);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_addr  <= CFG_LINE_PADDING;
        cfg_wdata <= p;
        @(posedge aclk);
        cfg_addr  <= CFG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        if (poke_spare) begin
            cfg_addr  <= CFG_SPARE;
            cfg_wdata <= CFG_W'($urandom_range(0, 8191));
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] extreme_size();
        case ($urandom_range(0, 3))
            0:       return 13'd4096;
            1:       return 13'd8191;
            2:       return 13'd0;
            default: return CFG_W'($urandom_range(0, 8191));
        endcase
    endfunction

    task automatic pick_regs();
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        if ($urandom_range(0, 9) == 0) begin
            w = extreme_size();
            h = extreme_size();
        end else begin
            w = CFG_W'($urandom_range(1, 24));
            h = CFG_W'($urandom_range(1, 6));
        end
        set_regs(w, CFG_W'($urandom_range(0, 8191)), h, $urandom_range(0, 4) == 0);
    endtask

    task automatic build_image(input int ops, input bit closing_eob);
        int kind;
        int n;
        stream.delete();
        repeat (ops) begin
            kind = $urandom_range(0, 99);
            if (kind < 36) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
                stream.push_back(BYTE_W'(n));
                stream.push_back(BYTE_W'($urandom_range(0, 255)));
            end else if (kind < 60) begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 9);
                stream.push_back(ESC_MARK);
                stream.push_back(BYTE_W'(n));
                repeat (n) stream.push_back(BYTE_W'($urandom_range(0, 255)));
                if (n % 2 == 1) stream.push_back(BYTE_W'($urandom_range(0, 255)));
            end else if (kind < 73) begin
                stream.push_back(ESC_MARK);
                stream.push_back(ESC_EOL);
            end else if (kind < 86) begin
                stream.push_back(ESC_MARK);
                stream.push_back(ESC_DELTA);
                stream.push_back(BYTE_W'(($urandom_range(0, 3) == 0) ?
                                         $urandom_range(0, 255) : $urandom_range(0, 7)));
                stream.push_back(BYTE_W'(($urandom_range(0, 7) == 0) ?
                                         $urandom_range(0, 255) : $urandom_range(0, 2)));
            end else if (kind < 90) begin
                stream.push_back(ESC_MARK);
                stream.push_back(ESC_EOB);
            end else begin
                stream.push_back(($urandom_range(0, 2) == 0) ? ESC_MARK :
                                 BYTE_W'($urandom_range(0, 255)));
            end
        end
        if (closing_eob) begin
            stream.push_back(ESC_MARK);
            stream.push_back(ESC_EOB);
        end
    endtask

    task automatic send_stream(input bit mark_first, input bit mark_last);
        for (int i = 0; i < stream.size(); i++)
            send_byte(stream[i], mark_first && i == 0, mark_last && i == stream.size() - 1);
    endtask

    initial begin
        int img;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = CFG_IMAGE_WIDTH;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_first     = 1'b0;
        s_last      = 1'b0;
        m_ready     = 1'b0;
        sent        = 0;
        calm        = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_regs(13'd8, 13'd3, 13'd2, 1'b1);
        send_byte(8'h03, 1'b1, 1'b0);
        send_byte(8'hAB, 1'b0, 1'b0);
        send_byte(ESC_MARK, 1'b0, 1'b0);
        send_byte(8'h03, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'h77, 1'b0, 1'b0);
        send_byte(ESC_MARK, 1'b0, 1'b0);
        send_byte(ESC_EOL, 1'b0, 1'b0);
        send_byte(ESC_MARK, 1'b0, 1'b0);
        send_byte(ESC_DELTA, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'h05, 1'b0, 1'b0);
        send_byte(ESC_MARK, 1'b1, 1'b0);
        send_byte(ESC_EOB, 1'b0, 1'b0);
        send_byte(8'h02, 1'b1, 1'b0);
        send_byte(8'h80, 1'b0, 1'b1);
        settle();
        set_regs(13'd8191, 13'd3, 13'd8191, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        settle();
        set_regs(13'd0, 13'd0, 13'd0, 1'b0);
        send_byte(8'h02, 1'b1, 1'b0);
        send_byte(8'h33, 1'b0, 1'b0);

        img = 0;
        while (sent < ITEMS) begin
            if (img % 3 == 0) begin
                settle();
                pick_regs();
            end
            if (img == 7) settle();
            calm = ($urandom_range(0, 3) == 0);
            build_image($urandom_range(1, 12), $urandom_range(0, 1) == 1);
            send_stream(1'b1, $urandom_range(0, 3) == 0);
            // shrink the buffer under an open image
            if ($urandom_range(0, 7) == 0) begin
                build_image($urandom_range(1, 6), 1'b0);
                send_stream(1'b1, 1'b0);
                settle();
                set_regs(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(0, 8191)),
                         CFG_W'($urandom_range(1, 2)), 1'b0);
                build_image($urandom_range(1, 4), 1'b0);
                send_stream(1'b0, 1'b0);
            end
            img++;
        end

        calm = 1'b0;
        settle();
        repeat (8) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
